// ===== design/sfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU package
// Shared constants, codes and control types for the ALU and its shift unit.
// ----------------------------------------------------------------------------
package sfpa_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int CNT_BITS      = 7;

    localparam logic [5:0] INT_BITS_RST  = 6'd16;
    localparam logic [4:0] FRAC_BITS_RST = 5'd16;

    // normalising stops once the shift count passes this
    localparam logic [6:0] NORM_LIMIT = 7'd32;

    localparam logic [1:0] CFG_INT_BITS  = 2'd0;
    localparam logic [1:0] CFG_FRAC_BITS = 2'd1;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_NEG  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_INV  = 4'd5,
        OP_GT   = 4'd6,
        OP_GE   = 4'd7,
        OP_LT   = 4'd8,
        OP_LE   = 4'd9,
        OP_EQ   = 4'd10,
        OP_NE   = 4'd11,
        OP_CAST = 4'd12,
        OP_FRAC = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STRIP,
        ST_NORM,
        ST_WAIT,
        ST_POST,
        ST_DONE
    } state_t;

    typedef enum logic {
        MODE_MUL,
        MODE_DIV
    } mode_t;

    typedef struct packed {
        logic                go;
        mode_t               mode;
        logic [CNT_BITS-1:0] count;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

// ===== design/sfpa_shift_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial shift unit
// Shift-add multiply and restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module sfpa_shift_unit #(
    parameter int WORD_BITS = sfpa_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sfpa_pkg::unit_cmd_t      cmd,
    input  logic [WORD_BITS-1:0]     opnd,
    input  logic [2*WORD_BITS-1:0]   load,
    output sfpa_pkg::unit_sts_t      sts,
    output logic [2*WORD_BITS-1:0]   result
);
    import sfpa_pkg::*;

    localparam int W = WORD_BITS;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    mode_t               mode_reg, mode_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] last_reg, last_next;
    logic [W-1:0]        opnd_reg, opnd_next;
    logic [W:0]          hi_reg, hi_next;
    logic [2*W-1:0]      lo_reg, lo_next;

    logic [W:0] sum;
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign sum   = hi_reg + (lo_reg[0] ? {1'b0, opnd_reg} : '0);
    assign trial = {hi_reg[W-1:0], lo_reg[2*W-1]};
    assign ge    = trial >= {1'b0, opnd_reg};
    assign diff  = trial - {1'b0, opnd_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        opnd_next = opnd_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (cmd.go)
        begin
            busy_next = 1'b1;
            mode_next = cmd.mode;
            cnt_next  = '0;
            last_next = cmd.count - 1'b1;
            opnd_next = opnd;
            hi_next   = '0;
            lo_next   = load;
        end
        else if (busy_reg)
        begin
            case (mode_reg)
                MODE_MUL:
                begin
                    // {hi, lo low half} shifts right one place after the add
                    hi_next = {1'b0, sum[W:1]};
                    lo_next = {lo_reg[2*W-1:W], sum[0], lo_reg[W-1:1]};
                end
                MODE_DIV:
                begin
                    hi_next = ge ? diff : trial;
                    lo_next = {lo_reg[2*W-2:0], ge};
                end
                default:
                begin
                    hi_next = hi_reg;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == last_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_MUL;
            cnt_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = (mode_reg == MODE_MUL) ? {hi_reg[W-1:0], lo_reg[W-1:0]} : lo_reg;

`ifndef SYNTHESIS
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |-> !busy_reg)
        else $error("shift unit started while busy");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("shift unit done while still busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= last_reg)
        else $error("shift unit count overran");
`endif

endmodule

// ===== design/saturating_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU
// Q-format ALU with configurable integer/fraction split and a bit-serial unit.
// ----------------------------------------------------------------------------
// Add, sub, neg, compares, cast and special cases go from decode straight to the
// output stage; multiply and fraction wait on the shift unit. Divide and inverse
// first run the trailing-zero strip and normalise one bit a cycle (33 places at
// most between them), then WORD_BITS unit steps. One word in flight; the next is
// taken while a result waits at the output. Reset clears control; int/frac bits
// come up at 16.
module saturating_fixed_point_alu #(
    parameter int WORD_BITS = sfpa_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // opcode[3:0], operand_a[35:4], operand_b[67:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // value[31:0], flag[32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    import sfpa_pkg::*;

    localparam int W = WORD_BITS;

    function automatic logic [W-1:0] mag_w(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // configuration
    logic [5:0] int_bits_reg;
    logic [4:0] frac_bits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_bits_reg  <= INT_BITS_RST;
            frac_bits_reg <= FRAC_BITS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INT_BITS:  int_bits_reg  <= cfg_data;
                CFG_FRAC_BITS: frac_bits_reg <= cfg_data[4:0];
                default:       int_bits_reg  <= int_bits_reg;
            endcase
        end
    end

    // format
    logic [5:0]     ib, room, t;
    logic [4:0]     fb;
    logic [2*W-1:0] fmt_max, fmt_lim;
    logic [W-1:0]   max_w, min_w;

    always_comb
    begin
        if (int_bits_reg == 6'd0)
            ib = 6'd1;
        else if (int_bits_reg > 6'(W))
            ib = 6'(W);
        else
            ib = int_bits_reg;
        room    = 6'(W) - ib;
        fb      = ({1'b0, frac_bits_reg} > room) ? room[4:0] : frac_bits_reg;
        t       = ib + {1'b0, fb};
        fmt_max = ((2*W)'(1) << (t - 6'd1)) - 1'b1;
        fmt_lim = fmt_max + 1'b1;
        max_w   = fmt_max[W-1:0];
        min_w   = ~fmt_max[W-1:0];
    end

    // control and datapath registers
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic signed [W-1:0]   a_reg, a_next;
    logic signed [W-1:0]   b_reg, b_next;
    logic [W-1:0]          na_reg, na_next;
    logic [W-1:0]          db_reg, db_next;
    logic [6:0]            i_reg, i_next;
    logic                  neg_reg, neg_next;
    logic [2*W-1:0]        q_reg, q_next;
    logic signed [W-1:0]   res_reg, res_next;
    logic                  flag_reg, flag_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [W-1:0]   out_value_reg, out_value_next;
    logic                  out_flag_reg, out_flag_next;

    unit_cmd_t      ucmd;
    unit_sts_t      usts;
    logic [W-1:0]   uopnd;
    logic [2*W-1:0] uload;
    logic [2*W-1:0] uresult;

    logic norm_more;
    logic out_free;
    logic in_acc;

    assign norm_more = (na_reg != '0) && (na_reg[W-1:W-2] == 2'b00) && (i_reg <= NORM_LIMIT);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    sfpa_shift_unit #(
        .WORD_BITS(W)
    ) u_shift (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ucmd),
        .opnd   (uopnd),
        .load   (uload),
        .sts    (usts),
        .result (uresult)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = ST_DECODE;
            ST_DECODE:
            begin
                case (op_reg)
                    OP_MUL:  state_next = ST_WAIT;
                    OP_DIV:  state_next = (b_reg == '0) ? ST_DONE : ST_STRIP;
                    OP_INV:  state_next = (a_reg == '0) ? ST_DONE : ST_STRIP;
                    OP_FRAC: state_next = (a_reg == '0 || b_reg == '0) ? ST_DONE : ST_WAIT;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_STRIP:
                if (db_reg[0])
                    state_next = ST_NORM;
            ST_NORM:
                if (!norm_more)
                    state_next = ST_WAIT;
            ST_WAIT:
                if (usts.done)
                    state_next = ST_POST;
            ST_POST:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    logic signed [2*W-1:0] cast_p;
    logic [2*W-1:0]        m_val, cap;
    logic [6:0]            fb7;

    always_comb
    begin
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        na_next        = na_reg;
        db_next        = db_reg;
        i_next         = i_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        flag_next      = flag_reg;
        ucmd.go        = 1'b0;
        ucmd.mode      = MODE_DIV;
        ucmd.count     = CNT_BITS'(W);
        uopnd          = '0;
        uload          = '0;
        fb7            = {2'b00, fb};
        cast_p         = $signed({{W{a_reg[W-1]}}, a_reg}) <<< fb;
        m_val          = '0;
        cap            = '0;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_flag_next  = out_flag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next = op_t'(s_axis_tdata[3:0]);
                    a_next  = s_axis_tdata[4 +: W];
                    b_next  = s_axis_tdata[36 +: W];
                end
            end
            ST_DECODE:
            begin
                res_next  = '0;
                flag_next = 1'b0;
                i_next    = '0;
                case (op_reg)
                    OP_ADD: res_next = a_reg + b_reg;
                    OP_SUB: res_next = a_reg - b_reg;
                    OP_NEG: res_next = -a_reg;
                    OP_MUL:
                    begin
                        neg_next   = a_reg[W-1] ^ b_reg[W-1];
                        ucmd.go    = 1'b1;
                        ucmd.mode  = MODE_MUL;
                        ucmd.count = CNT_BITS'(W);
                        uopnd      = mag_w(a_reg);
                        uload      = {{W{1'b0}}, mag_w(b_reg)};
                    end
                    OP_DIV:
                    begin
                        if (b_reg == '0)
                            res_next = a_reg[W-1] ? min_w : max_w;
                        neg_next = a_reg[W-1] ^ b_reg[W-1];
                        na_next  = mag_w(a_reg);
                        db_next  = mag_w(b_reg);
                    end
                    OP_INV:
                    begin
                        if (a_reg == '0)
                            res_next = max_w;
                        neg_next = a_reg[W-1];
                        na_next  = W'(1) << fb;
                        db_next  = mag_w(a_reg);
                    end
                    OP_GT: flag_next = a_reg > b_reg;
                    OP_GE: flag_next = a_reg >= b_reg;
                    OP_LT: flag_next = a_reg < b_reg;
                    OP_LE: flag_next = a_reg <= b_reg;
                    OP_EQ: flag_next = a_reg == b_reg;
                    OP_NE: flag_next = a_reg != b_reg;
                    OP_CAST:
                    begin
                        if (cast_p > $signed(fmt_max))
                            res_next = max_w;
                        else if (cast_p < $signed(~fmt_max))
                            res_next = min_w;
                        else
                            res_next = cast_p[W-1:0];
                    end
                    OP_FRAC:
                    begin
                        if (a_reg == '0)
                            res_next = '0;
                        else if (b_reg == '0)
                            res_next = a_reg[W-1] ? min_w : max_w;
                        else
                        begin
                            neg_next   = a_reg[W-1] ^ b_reg[W-1];
                            ucmd.go    = 1'b1;
                            ucmd.mode  = MODE_DIV;
                            ucmd.count = CNT_BITS'(2 * W);
                            uopnd      = mag_w(b_reg);
                            uload      = {{W{1'b0}}, mag_w(a_reg)} << fb;
                        end
                    end
                    default: res_next = '0;
                endcase
            end
            ST_STRIP:
            begin
                if (!db_reg[0])
                begin
                    db_next = db_reg >> 1;
                    i_next  = i_reg + 1'b1;
                end
            end
            ST_NORM:
            begin
                if (norm_more)
                begin
                    na_next = na_reg << 1;
                    i_next  = i_reg + 1'b1;
                end
                else
                begin
                    ucmd.go    = 1'b1;
                    ucmd.mode  = MODE_DIV;
                    ucmd.count = CNT_BITS'(W);
                    uopnd      = db_reg;
                    uload      = {na_reg, {W{1'b0}}};
                end
            end
            ST_WAIT:
            begin
                if (usts.done)
                    q_next = uresult;
            end
            ST_POST:
            begin
                if (op_reg == OP_FRAC)
                begin
                    // quotient truncates toward zero; negative side may reach MIN
                    if (!neg_reg)
                        res_next = (q_reg > fmt_max) ? max_w : q_reg[W-1:0];
                    else
                        res_next = (q_reg > fmt_lim) ? min_w : -q_reg[W-1:0];
                end
                else
                begin
                    if (op_reg == OP_MUL)
                        m_val = q_reg >> fb;
                    else if (i_reg < fb7)
                        m_val = q_reg << (fb7 - i_reg);
                    else
                        m_val = q_reg >> (i_reg - fb7);
                    cap      = (m_val > fmt_max) ? fmt_max : m_val;
                    res_next = neg_reg ? -cap[W-1:0] : cap[W-1:0];
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase

        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_value_next = res_reg;
            out_flag_next  = flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        na_reg        <= na_next;
        db_reg        <= db_next;
        i_reg         <= i_next;
        neg_reg       <= neg_next;
        q_reg         <= q_next;
        res_reg       <= res_next;
        flag_reg      <= flag_next;
        out_value_reg <= out_value_next;
        out_flag_reg  <= out_flag_next;
    end

    logic signed [31:0] value32;

    assign value32       = 32'(out_value_reg);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_flag_reg, value32};

`ifndef SYNTHESIS
    a_flag_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("compare word carries a nonzero value");
    a_strip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STRIP) |-> (db_reg != '0))
        else $error("trailing-zero strip on a zero divisor");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        usts.done |-> (state_reg == ST_WAIT))
        else $error("shift unit finished outside the wait state");
    a_go_source: assert property (@(posedge clk) disable iff (!rst_n)
        ucmd.go |-> (state_reg == ST_DECODE || state_reg == ST_NORM))
        else $error("shift unit started from an unexpected state");
`endif

endmodule

// ===== dv/sfpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU checker
// Watches the config, input and result channels, predicts each result word
// from the current Q format and compares it field by field in order.
// ----------------------------------------------------------------------------
module sfpa_checker
    import sfpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        flag;
    } alu_res_t;

    alu_res_t    expected_q[$];
    logic [5:0]  int_bits;
    logic [4:0]  frac_bits;
    int unsigned frac_n;
    longint      q_max;
    longint      q_min;

    assign pending = expected_q.size();

    function automatic void update_format();
        int unsigned ib;
        int unsigned fb;
        ib = int_bits;
        fb = frac_bits;
        if (ib < 1) ib = 1;
        if (ib > 32) ib = 32;
        if (fb > 32 - ib) fb = 32 - ib;
        frac_n = fb;
        q_max  = (longint'(1) << (ib + fb - 1)) - 1;
        q_min  = -(longint'(1) << (ib + fb - 1));
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > q_max) return q_max;
        if (v < q_min) return q_min;
        return v;
    endfunction

    function automatic longint apply_sign(bit neg, logic [63:0] mag);
        longint m;
        m = (mag > 64'(q_max)) ? q_max : longint'(mag);
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint quotient_q(bit neg, logic [63:0] num, logic [63:0] den);
        int          sh;
        logic [63:0] q;
        sh = 0;
        while (!den[0])
        begin
            den = den >> 1;
            sh++;
        end
        if (num != 0)
        begin
            while (num < (64'd1 << 30) && sh <= 32)
            begin
                num = num << 1;
                sh++;
            end
        end
        q = num / den;
        if (sh < int'(frac_n)) q = q << (int'(frac_n) - sh);
        else q = q >> (sh - int'(frac_n));
        return apply_sign(neg, q);
    endfunction

    function automatic alu_res_t alu_predict(logic [3:0] op, logic [31:0] ra, logic [31:0] rb);
        longint   a;
        longint   b;
        longint   v;
        alu_res_t r;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        v = 0;
        r.flag = 1'b0;
        case (op)
            OP_ADD:  v = longint'($signed(32'(a + b)));
            OP_SUB:  v = longint'($signed(32'(a - b)));
            OP_NEG:  v = longint'($signed(32'(-a)));
            OP_MUL:  v = apply_sign((a < 0) != (b < 0),
                                    (magnitude(a) * magnitude(b)) >> frac_n);
            OP_DIV:
                if (b == 0) v = (a < 0) ? q_min : q_max;
                else v = quotient_q((a < 0) != (b < 0), magnitude(a), magnitude(b));
            OP_INV:
                if (a == 0) v = q_max;
                else v = quotient_q(a < 0, 64'd1 << frac_n, magnitude(a));
            OP_GT:   r.flag = a > b;
            OP_GE:   r.flag = a >= b;
            OP_LT:   r.flag = a < b;
            OP_LE:   r.flag = a <= b;
            OP_EQ:   r.flag = a == b;
            OP_NE:   r.flag = a != b;
            OP_CAST: v = clamp_q(a * (longint'(1) << frac_n));
            OP_FRAC:
                if (a == 0) v = 0;
                else if (b == 0) v = (a < 0) ? q_min : q_max;
                else v = clamp_q((a * (longint'(1) << frac_n)) / b);
            default: v = 0;
        endcase
        r.value = v[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alu_res_t got;
        alu_res_t want;
        if (!rst_n)
        begin
            int_bits   = INT_BITS_RST;
            frac_bits  = FRAC_BITS_RST;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            // result side first: a word accepted this edge predates any new input
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value = m_axis_tdata[31:0];
                got.flag  = m_axis_tdata[32];
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: value %h flag %b",
                                 got.value, got.flag);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: value exp %h got %h, flag exp %b got %b",
                                     want.value, got.value, want.flag, got.flag);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_INT_BITS) int_bits = cfg_data;
                else if (cfg_index == CFG_FRAC_BITS) frac_bits = cfg_data[4:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                update_format();
                expected_q.push_back(alu_predict(s_axis_tdata[3:0], s_axis_tdata[35:4],
                                                 s_axis_tdata[67:36]));
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating fixed-point ALU testbench
// Directed corner words then random operations over a range of Q formats,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import sfpa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          quiet_phase;
    bit          hold_req;

    saturating_fixed_point_alu u_top (.*);

    sfpa_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("FAIL saturating_fixed_point_alu");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                m_axis_tready = 1'b0;
                repeat (600) @(negedge clk);
                held = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                n = $urandom_range(1, 13);
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'($urandom_range(0, 255)) << $urandom_range(0, 24);
            4: return -(32'($urandom_range(1, 255)) << $urandom_range(0, 24));
            default: return $urandom;
        endcase
    endfunction

    // valid stays up after the handshake; the next word or an idle gap replaces it
    task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        int n;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, b, a, op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic set_format(logic [5:0] ib, logic [5:0] fb);
        drain();
        write_reg(CFG_INT_BITS, ib);
        write_reg(CFG_FRAC_BITS, fb);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [5:0]  ib;
        logic [5:0]  fb;
        logic [31:0] a;
        logic [31:0] b;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cycle_count   = 0;
        quiet_phase   = 1'b0;
        hold_req      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every op plus extremes, zero divisor, zero numerator
        for (int op = 0; op < 16; op++)
            send_word(4'(op), 32'h8000_0000, 32'h7fff_ffff);
        send_word(OP_DIV, 32'h0003_0000, 32'd0);
        send_word(OP_DIV, 32'hffff_0000, 32'd0);
        send_word(OP_INV, 32'd0, 32'd5);
        send_word(OP_FRAC, 32'd0, 32'd0);
        send_word(OP_FRAC, 32'hffff_fffd, 32'd0);
        send_word(OP_FRAC, 32'd7, 32'hffff_fffd);
        send_word(OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_DIV, 32'd0, 32'h0001_0000);

        // long hold-off while words keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(4'($urandom_range(0, 13)), rand_operand(), rand_operand());

        for (int ph = 0; ph < 13; ph++)
        begin
            case (ph)
                0: begin ib = 6'd1;  fb = 6'd0;  end
                1: begin ib = 6'd32; fb = 6'd0;  end
                2: begin ib = 6'd1;  fb = 6'd31; end
                3: begin ib = 6'd0;  fb = 6'd31; end
                4: begin ib = 6'd63; fb = 6'd31; end
                5: begin ib = 6'd16; fb = 6'd16; end
                6: begin ib = 6'd8;  fb = 6'd24; end
                default:
                begin
                    ib = 6'($urandom);
                    fb = 6'($urandom_range(0, 31));
                end
            endcase
            set_format(ib, fb);
            if (ph == 12) quiet_phase = 1'b1;
            for (int i = 0; i < 150; i++)
            begin
                a = rand_operand();
                b = rand_operand();
                send_word(4'($urandom_range(0, 15)), a, b);
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS saturating_fixed_point_alu");
        else
            $display("FAIL saturating_fixed_point_alu");
        $finish;
    end

endmodule
